// File: rtl/sscs_pkg.sv
// Shared types, constants and the seven-segment font for the centered scan unit.
package sscs_pkg;

    localparam int DIGIT_COUNT_DEF = 8;
    localparam int MAX_WORDS       = 8;
    localparam int CHAR_W          = 8;
    localparam int MSG_CHARS       = 8;
    localparam int COUNT_W         = 4;
    localparam int SEG_W           = 8;
    localparam int SEL_W           = 8;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
    localparam logic [SEG_W-1:0] SEG_DOT   = 8'h80;
    localparam logic [SEL_W-1:0] SEL_NONE  = 8'hFF;

    typedef struct packed {
        logic [SEL_W-1:0] digit_select;
        logic [SEG_W-1:0] segment_bits;
        logic             last_digit;
    } t_scan_word;

    function automatic logic [SEG_W-1:0] font_lookup(input logic [CHAR_W-1:0] ch);
        logic [SEG_W-1:0] seg;
        case (ch)
            "0", "O":           seg = 8'h3F;
            "1", "I":           seg = 8'h06;
            "2":                seg = 8'h5B;
            "3":                seg = 8'h4F;
            "4":                seg = 8'h66;
            "5", "s", "S":      seg = 8'h6D;
            "6", "G":           seg = 8'h7D;
            "7":                seg = 8'h07;
            "8":                seg = 8'h7F;
            "9", "q", "Q":      seg = 8'h67;
            "A", "a":           seg = 8'h77;
            "b", "B":           seg = 8'h7C;
            "c":                seg = 8'h58;
            "C":                seg = 8'h39;
            "D", "d":           seg = 8'h5E;
            "e", "E":           seg = 8'h79;
            "f", "F":           seg = 8'h71;
            "g":                seg = 8'h6F;
            "H":                seg = 8'h76;
            "h":                seg = 8'h74;
            "i":                seg = 8'h04;
            "j", "J":           seg = 8'h0E;
            "k", "K":           seg = 8'h7A;
            "L":                seg = 8'h38;
            "l":                seg = 8'h30;
            "n", "N":           seg = 8'h54;
            "o":                seg = 8'h5C;
            "P", "p":           seg = 8'h73;
            "r":                seg = 8'h50;
            "R":                seg = 8'h33;
            "t", "T":           seg = 8'h78;
            "U":                seg = 8'h3E;
            "v", "V", "u":      seg = 8'h1C;
            "W", "w":           seg = 8'h7E;
            "y", "Y":           seg = 8'h6E;
            "-":                seg = 8'h40;
            ".":                seg = SEG_DOT;
            default:            seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// File: rtl/sscs_word_enc.sv
// Combinational encoder that builds the scan word for one digit position.
module sscs_word_enc #(
    parameter int WORDS = sscs_pkg::MAX_WORDS,
    parameter int POS_W = $clog2(WORDS)
) (
    input  logic [sscs_pkg::CHAR_W*sscs_pkg::MSG_CHARS-1:0] i_msg,
    input  logic [sscs_pkg::MSG_CHARS-1:0]                  i_dots,
    input  logic [sscs_pkg::COUNT_W-1:0]                    i_cnt,
    input  logic [POS_W-1:0]                                i_pos,
    output sscs_pkg::t_scan_word                            o_word
);

    localparam logic [sscs_pkg::COUNT_W-1:0] HALF =
        sscs_pkg::COUNT_W'(WORDS / 2);

    logic [sscs_pkg::COUNT_W-1:0] start;
    logic [sscs_pkg::COUNT_W-1:0] pos_ext;
    logic [sscs_pkg::COUNT_W-1:0] offs;
    logic [2:0]                   k;
    logic                         in_win;
    logic [sscs_pkg::CHAR_W-1:0]  ch;
    logic [sscs_pkg::SEG_W-1:0]   seg;

    always_comb begin
        start   = HALF - (i_cnt >> 1);
        pos_ext = sscs_pkg::COUNT_W'(i_pos);
        offs    = pos_ext - start;
        k       = offs[2:0];
        in_win  = (i_cnt != '0) && (pos_ext >= start) && (pos_ext < start + i_cnt);
        ch      = i_msg[{k, 3'b000} +: sscs_pkg::CHAR_W];
        seg     = sscs_pkg::font_lookup(ch);
        if (i_dots[k]) begin
            seg = seg | sscs_pkg::SEG_DOT;
        end
        o_word.segment_bits = in_win ? seg : sscs_pkg::SEG_BLANK;
        o_word.digit_select = ~(sscs_pkg::SEL_W'(1) << i_pos);
        o_word.last_digit   = (i_pos == POS_W'(WORDS - 1));
    end

endmodule

// File: rtl/seven_segment_centered_scan_unit.sv
// Top level: message register, position counter and scan word output register.
// An accepted message is registered, then its first word is encoded into the output
// register. Words follow one per cycle unless i_ready stalls them, min(DIGIT_COUNT, 8)
// per message, limited by the single word encoder. The next message is taken in the
// cycle the last word is loaded, so back-to-back messages give an unbroken word stream.
// Synchronous active-low reset clears the busy flag and the output valid.
module seven_segment_centered_scan_unit #(
    parameter int DIGIT_COUNT = sscs_pkg::DIGIT_COUNT_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    output logic                                            o_ready,
    input  logic [sscs_pkg::CHAR_W*sscs_pkg::MSG_CHARS-1:0] i_message_chars,
    input  logic [sscs_pkg::MSG_CHARS-1:0]                  i_dot_flags,
    input  logic [sscs_pkg::COUNT_W-1:0]                    i_char_count,
    output logic                                            o_valid,
    input  logic                                            i_ready,
    output logic [sscs_pkg::SEL_W-1:0]                      o_digit_select,
    output logic [sscs_pkg::SEG_W-1:0]                      o_segment_bits,
    output logic                                            o_last_digit
);

    localparam int WORDS = (DIGIT_COUNT > sscs_pkg::MAX_WORDS) ? sscs_pkg::MAX_WORDS
                                                               : DIGIT_COUNT;
    localparam int POS_W = $clog2(WORDS);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WORDS - 1);
    localparam logic [sscs_pkg::COUNT_W-1:0] WORDS_CNT = sscs_pkg::COUNT_W'(WORDS);

    logic [sscs_pkg::CHAR_W*sscs_pkg::MSG_CHARS-1:0] r_msg;
    logic [sscs_pkg::MSG_CHARS-1:0]                  r_dots;
    logic [sscs_pkg::COUNT_W-1:0]                    r_cnt;
    logic [sscs_pkg::COUNT_W-1:0]                    n_cnt;
    logic [POS_W-1:0]                                r_pos;
    logic                                            r_busy;
    logic                                            r_out_valid;
    sscs_pkg::t_scan_word                            r_word;
    sscs_pkg::t_scan_word                            enc_word;
    logic                                            advance;
    logic                                            in_beat;

    sscs_word_enc #(
        .WORDS (WORDS),
        .POS_W (POS_W)
    ) u_enc (
        .i_msg  (r_msg),
        .i_dots (r_dots),
        .i_cnt  (r_cnt),
        .i_pos  (r_pos),
        .o_word (enc_word)
    );

    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_busy || (advance && (r_pos == LAST_POS));
    assign in_beat = i_valid && o_ready;
    assign n_cnt   = (i_char_count > WORDS_CNT) ? WORDS_CNT : i_char_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (in_beat) begin
                r_busy <= 1'b1;
                r_pos  <= '0;
            end else if (r_busy && advance) begin
                r_pos <= r_pos + POS_W'(1);
                if (r_pos == LAST_POS) begin
                    r_busy <= 1'b0;
                end
            end
            if (advance) begin
                r_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_msg  <= i_message_chars;
            r_dots <= i_dot_flags;
            r_cnt  <= n_cnt;
        end
        if (advance && r_busy) begin
            r_word <= enc_word;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_digit_select = r_word.digit_select;
    assign o_segment_bits = r_word.segment_bits;
    assign o_last_digit   = r_word.last_digit;

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot(~o_digit_select))
        else $error("Digit select is not a single active-low bit.");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_digit) |-> !o_digit_select[WORDS-1])
        else $error("Last beat does not select the final position.");

    a_take_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && r_busy) |-> (r_pos == LAST_POS))
        else $error("New message taken before the scan finished.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_busy && r_pos == '0))
        else $error("Accepted message did not start a scan.");

endmodule
